FILE: rtl/rrc_pkg.sv
// ============================================================================
// Region registration cache package
// Shared types, codes and constants for the region registration cache.
// ============================================================================
package rrc_pkg;

    // Default number of table slots.
    localparam int TABLE_DEPTH_DEF = 64;

    // Device memory always uses 64 KiB pages.
    localparam logic [63:0] DEVICE_PAGE = 64'(64 * 1024);
    localparam logic [63:0] DEVICE_MASK = DEVICE_PAGE - 64'd1;

    localparam logic [31:0] REFS_MAX = 32'hFFFF_FFFF;

    // Request and memory kinds.
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_RELEASE  = 1'b1;
    localparam logic MEM_HOST     = 1'b0;
    localparam logic MEM_DEVICE   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_ENTRIES     = 2'd0;
    localparam logic [1:0] CFG_MAX_REGION_SIZE = 2'd1;
    localparam logic [1:0] CFG_HOST_PAGE_LOG2  = 2'd2;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_REUSED    = 3'd1,
        ST_LAST_REL  = 3'd2,
        ST_STILL_REF = 3'd3,
        ST_BAD_ARG   = 3'd4,
        ST_FULL      = 3'd5,
        ST_NOT_FOUND = 3'd6,
        ST_COUNT_ERR = 3'd7
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic [63:0] start_address;
        logic [63:0] length;
        logic        mem_type;
        logic [15:0] entry_handle;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] handle_out;
        logic [63:0] aligned_start;
        logic [63:0] aligned_end;
        logic [31:0] ref_count;
    } t_rsp;

    // One table slot.
    typedef struct packed {
        logic [63:0] start_addr;
        logic [63:0] end_addr;
        logic        kind;
        logic [31:0] refs;
        logic [15:0] tag;
    } t_entry;

    // What the compare unit checks a slot against.
    typedef struct packed {
        logic        is_release;
        logic        kind;
        logic [63:0] base;
        logic [63:0] end_addr;
        logic [15:0] tag;
    } t_match_req;

endpackage

FILE: rtl/rrc_entry_ram.sv
// ============================================================================
// Region registration cache entry memory
// One write port and one read port with registered read data.
// ============================================================================
module rrc_entry_ram #(
    parameter int DEPTH = rrc_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  rrc_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output rrc_pkg::t_entry o_rd_data
);

    rrc_pkg::t_entry r_mem [DEPTH];
    rrc_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rrc_match.sv
// ============================================================================
// Region registration cache compare unit
// Checks one slot for range containment or for a handle match.
// ============================================================================
module rrc_match (
    input  rrc_pkg::t_entry     i_entry,
    input  rrc_pkg::t_match_req i_req,
    output logic                o_hit
);

    logic contains;

    // The slot must hold the whole widened range and be of the same kind.
    assign contains = (i_entry.kind == i_req.kind)
                   && (i_entry.start_addr <= i_req.base)
                   && (i_req.end_addr <= i_entry.end_addr);

    assign o_hit = i_req.is_release ? (i_entry.tag == i_req.tag) : contains;

endmodule

FILE: rtl/region_registration_cache_top.sv
// ============================================================================
// Region registration cache
// Reference-counted table of page-aligned memory ranges with handles.
// ============================================================================
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-------------------------
//  request  | in        | i_in_valid / o_in_ready   | i_in_word  (t_req)
//  result   | out       | o_out_valid / i_out_ready | o_out_word (t_rsp)
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A register request passes through accept, three adder steps and the size check, a scan
// that reads the live slots in order, then update and hand-over.
// A release passes through accept, scan, update and hand-over, plus a read and a write to
// move the last slot into the hole. A hit ends the scan early.
// Reset clears the live count and handle counter and loads the default configuration; slots stay undefined.
// A stalled result waits in the output register while the next request is already taken.
// ============================================================================
module region_registration_cache_top #(
    parameter int TABLE_DEPTH = rrc_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rrc_pkg::t_req i_in_word,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rrc_pkg::t_rsp o_out_word,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    // Wide enough for the live count and the 7-bit admission limit alike.
    localparam int LCW = (CW > 7) ? CW : 7;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_ADD_OFS  = 11'b000_0000_0010,
        S_ADD_MASK = 11'b000_0000_0100,
        S_ADD_END  = 11'b000_0000_1000,
        S_LIMIT    = 11'b000_0001_0000,
        S_SCAN     = 11'b000_0010_0000,
        S_HIT      = 11'b000_0100_0000,
        S_MISS     = 11'b000_1000_0000,
        S_MOVE_RD  = 11'b001_0000_0000,
        S_MOVE_WR  = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration.
    logic [6:0]  r_max_entries;
    logic [63:0] r_max_size;
    logic [4:0]  r_host_log2;

    // Table bookkeeping.
    logic [CW-1:0] r_live, n_live;
    logic [15:0]   r_next_tag, n_next_tag;

    // Request and the widened range.
    rrc_pkg::t_req r_req, n_req;
    logic [63:0]   r_mask, n_mask;
    logic [63:0]   r_base, n_base;
    logic [63:0]   r_sum, n_sum;
    logic [63:0]   r_size, n_size;
    logic [63:0]   r_end, n_end;

    // Scan pipeline.
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_cmp_valid, n_cmp_valid;
    logic [AW-1:0]   r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]   r_hit_idx, n_hit_idx;
    rrc_pkg::t_entry r_ent, n_ent;

    // Pending and presented results.
    rrc_pkg::t_rsp r_rsp, n_rsp;
    rrc_pkg::t_rsp r_out_word, n_out_word;
    logic          r_out_valid, n_out_valid;

    // Shared adder.
    logic [63:0] add_a, add_b;
    logic [64:0] add_sum;

    // Memory ports.
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    rrc_pkg::t_entry wr_data, rd_data;

    // Compare unit.
    rrc_pkg::t_match_req match_req;
    logic                match_hit;

    logic [63:0]   accept_mask;
    logic [31:0]   refs_inc;
    logic [LCW-1:0] live_ext, max_ext;
    logic          table_full;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};

    assign accept_mask = (i_in_word.mem_type == rrc_pkg::MEM_DEVICE)
                       ? rrc_pkg::DEVICE_MASK
                       : ((64'd1 << r_host_log2) - 64'd1);

    assign refs_inc = (r_ent.refs == rrc_pkg::REFS_MAX) ? r_ent.refs
                                                        : r_ent.refs + 32'd1;

    assign live_ext   = LCW'(r_live);
    assign max_ext    = LCW'(r_max_entries);
    assign table_full = (live_ext >= max_ext) || (r_live >= CW'(TABLE_DEPTH));

    assign match_req.is_release = r_req.req_type;
    assign match_req.kind       = r_req.mem_type;
    assign match_req.base       = r_base;
    assign match_req.end_addr   = r_end;
    assign match_req.tag        = r_req.entry_handle;

    rrc_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rrc_match u_match (
        .i_entry (rd_data),
        .i_req   (match_req),
        .o_hit   (match_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_next_tag  = r_next_tag;
        n_req       = r_req;
        n_mask      = r_mask;
        n_base      = r_base;
        n_sum       = r_sum;
        n_size      = r_size;
        n_end       = r_end;
        n_idx       = r_idx;
        n_cmp_valid = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_hit_idx   = r_hit_idx;
        n_ent       = r_ent;
        n_rsp       = r_rsp;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && !i_out_ready;
        add_a       = r_sum;
        add_b       = r_mask;
        wr_en       = 1'b0;
        wr_addr     = r_hit_idx;
        wr_data     = r_ent;
        rd_en       = 1'b0;
        rd_addr     = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_in_word;
                    n_mask = accept_mask;
                    n_base = i_in_word.start_address & ~accept_mask;
                    n_idx  = '0;
                    if (i_in_word.req_type == rrc_pkg::REQ_RELEASE) begin
                        n_state = (r_live == '0) ? S_MISS : S_SCAN;
                    end else begin
                        n_state = S_ADD_OFS;
                    end
                end
            end
            S_ADD_OFS: begin
                // Length plus the offset of the start within its page.
                add_a = r_req.length;
                add_b = r_req.start_address & r_mask;
                n_sum = add_sum[63:0];
                if (r_req.start_address == '0 || r_req.length == '0 || add_sum[64]) begin
                    n_rsp   = '{rrc_pkg::ST_BAD_ARG, 16'd0, 64'd0, 64'd0, 32'd0};
                    n_state = S_RESP;
                end else begin
                    n_state = S_ADD_MASK;
                end
            end
            S_ADD_MASK: begin
                // Round the size up to a whole number of pages.
                add_a  = r_sum;
                add_b  = r_mask;
                n_size = add_sum[63:0] & ~r_mask;
                if (add_sum[64]) begin
                    n_rsp   = '{rrc_pkg::ST_BAD_ARG, 16'd0, 64'd0, 64'd0, 32'd0};
                    n_state = S_RESP;
                end else begin
                    n_state = S_ADD_END;
                end
            end
            S_ADD_END: begin
                add_a = r_base;
                add_b = r_size;
                n_end = add_sum[63:0];
                if (add_sum[64]) begin
                    n_rsp   = '{rrc_pkg::ST_BAD_ARG, 16'd0, 64'd0, 64'd0, 32'd0};
                    n_state = S_RESP;
                end else begin
                    n_state = S_LIMIT;
                end
            end
            S_LIMIT: begin
                if (r_max_size != '0 && r_size > r_max_size) begin
                    n_rsp   = '{rrc_pkg::ST_BAD_ARG, 16'd0, 64'd0, 64'd0, 32'd0};
                    n_state = S_RESP;
                end else begin
                    n_idx   = '0;
                    n_state = (r_live == '0) ? S_MISS : S_SCAN;
                end
            end
            S_SCAN: begin
                // One read issued per cycle; the slot read last cycle is compared.
                if (r_idx < r_live) begin
                    rd_en       = 1'b1;
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[AW-1:0];
                    n_idx       = r_idx + CW'(1);
                end
                if (r_cmp_valid) begin
                    if (match_hit) begin
                        n_ent       = rd_data;
                        n_hit_idx   = r_cmp_idx;
                        n_cmp_valid = 1'b0;
                        n_state     = S_HIT;
                    end else if (CW'(r_cmp_idx) == r_live - CW'(1)) begin
                        n_cmp_valid = 1'b0;
                        n_state     = S_MISS;
                    end
                end
            end
            S_HIT: begin
                if (r_req.req_type == rrc_pkg::REQ_REGISTER) begin
                    wr_en        = 1'b1;
                    wr_data.refs = refs_inc;
                    n_rsp = '{rrc_pkg::ST_REUSED, r_ent.tag, r_ent.start_addr,
                              r_ent.end_addr, refs_inc};
                    n_state = S_RESP;
                end else if (r_ent.refs == '0) begin
                    n_rsp = '{rrc_pkg::ST_COUNT_ERR, r_req.entry_handle,
                              r_ent.start_addr, r_ent.end_addr, 32'd0};
                    n_state = S_RESP;
                end else if (r_ent.refs != 32'd1) begin
                    wr_en        = 1'b1;
                    wr_data.refs = r_ent.refs - 32'd1;
                    n_rsp = '{rrc_pkg::ST_STILL_REF, r_req.entry_handle,
                              r_ent.start_addr, r_ent.end_addr, r_ent.refs - 32'd1};
                    n_state = S_RESP;
                end else begin
                    // Last reference gone: the last live slot fills the hole.
                    n_live = r_live - CW'(1);
                    n_rsp = '{rrc_pkg::ST_LAST_REL, r_req.entry_handle,
                              r_ent.start_addr, r_ent.end_addr, 32'd0};
                    n_state = (CW'(r_hit_idx) < r_live - CW'(1)) ? S_MOVE_RD : S_RESP;
                end
            end
            S_MISS: begin
                if (r_req.req_type == rrc_pkg::REQ_RELEASE) begin
                    n_rsp = '{rrc_pkg::ST_NOT_FOUND, r_req.entry_handle,
                              64'd0, 64'd0, 32'd0};
                end else if (table_full) begin
                    n_rsp = '{rrc_pkg::ST_FULL, 16'd0, r_base, r_end, 32'd0};
                end else begin
                    wr_en              = 1'b1;
                    wr_addr            = r_live[AW-1:0];
                    wr_data.start_addr = r_base;
                    wr_data.end_addr   = r_end;
                    wr_data.kind       = r_req.mem_type;
                    wr_data.refs       = 32'd1;
                    wr_data.tag        = r_next_tag;
                    n_rsp = '{rrc_pkg::ST_NEW, r_next_tag, r_base, r_end, 32'd1};
                    n_next_tag = r_next_tag + 16'd1;
                    n_live     = r_live + CW'(1);
                end
                n_state = S_RESP;
            end
            S_MOVE_RD: begin
                // The live count is already decremented, so it names the last slot.
                rd_en   = 1'b1;
                rd_addr = r_live[AW-1:0];
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_hit_idx;
                wr_data = rd_data;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_word  = r_rsp;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_live        <= '0;
            r_next_tag    <= '0;
            r_cmp_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_max_entries <= 7'd64;
            r_max_size    <= '0;
            r_host_log2   <= 5'd12;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_next_tag  <= n_next_tag;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rrc_pkg::CFG_MAX_ENTRIES:     r_max_entries <= i_cfg_data[6:0];
                    rrc_pkg::CFG_MAX_REGION_SIZE: r_max_size    <= i_cfg_data;
                    rrc_pkg::CFG_HOST_PAGE_LOG2:  r_host_log2   <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_mask     <= n_mask;
        r_base     <= n_base;
        r_sum      <= n_sum;
        r_size     <= n_size;
        r_end      <= n_end;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_ent      <= n_ent;
        r_rsp      <= n_rsp;
        r_out_word <= n_out_word;
    end

endmodule

FILE: tb/region_registration_cache_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Region registration cache testbench
// Drives register and release requests through the valid/ready channels,
// predicts every result word with a cycle-free model of the table, and
// compares the result words in order, across several configuration settings.
// ============================================================================
module region_registration_cache_top_tb;

    localparam int DEPTH           = rrc_pkg::TABLE_DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int LAST_PHASE      = 6;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 80;

    // Keeps its own copy of the table and the settings, computes the result
    // word for every accepted request and matches the words that come back.
    class region_cache_scoreboard;
        logic [63:0] slot_lo   [DEPTH];
        logic [63:0] slot_hi   [DEPTH];
        logic        slot_kind [DEPTH];
        logic [31:0] slot_refs [DEPTH];
        logic [15:0] slot_tag  [DEPTH];
        int          live_slots;
        logic [15:0] tag_next;

        logic [6:0]  cfg_cap;
        logic [63:0] cfg_size_limit;
        logic [4:0]  cfg_page_log2;

        rrc_pkg::t_rsp pending_rsp [$];
        int            failures;
        int            requests;
        int            seen [8];

        function new();
            live_slots     = 0;
            tag_next       = '0;
            cfg_cap        = 7'd64;
            cfg_size_limit = '0;
            cfg_page_log2  = 5'd12;
            failures       = 0;
            requests       = 0;
            foreach (seen[k]) seen[k] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                rrc_pkg::CFG_MAX_ENTRIES:     cfg_cap = data[6:0];
                rrc_pkg::CFG_MAX_REGION_SIZE: cfg_size_limit = data;
                rrc_pkg::CFG_HOST_PAGE_LOG2:  cfg_page_log2 = data[4:0];
                default: ;
            endcase
        endfunction

        function void note_request(rrc_pkg::t_req w);
            rrc_pkg::t_rsp r;
            logic [63:0]   mask, base, offset, size, stop;
            logic          bad;
            int            hit, last;

            r = '0;
            hit = -1;
            requests++;
            if (w.req_type == rrc_pkg::REQ_RELEASE) begin
                // The lowest slot carrying the handle wins when handles repeat.
                for (int i = 0; i < live_slots && hit < 0; i++)
                    if (slot_tag[i] == w.entry_handle) hit = i;
                r.handle_out = w.entry_handle;
                if (hit < 0) begin
                    r.status = rrc_pkg::ST_NOT_FOUND;
                end else if (slot_refs[hit] == '0) begin
                    r.status        = rrc_pkg::ST_COUNT_ERR;
                    r.aligned_start = slot_lo[hit];
                    r.aligned_end   = slot_hi[hit];
                end else begin
                    slot_refs[hit]  = slot_refs[hit] - 32'd1;
                    r.aligned_start = slot_lo[hit];
                    r.aligned_end   = slot_hi[hit];
                    if (slot_refs[hit] != '0) begin
                        r.status    = rrc_pkg::ST_STILL_REF;
                        r.ref_count = slot_refs[hit];
                    end else begin
                        // The last live slot moves into the freed one.
                        r.status   = rrc_pkg::ST_LAST_REL;
                        live_slots = live_slots - 1;
                        last       = live_slots;
                        if (hit < last) begin
                            slot_lo[hit]   = slot_lo[last];
                            slot_hi[hit]   = slot_hi[last];
                            slot_kind[hit] = slot_kind[last];
                            slot_refs[hit] = slot_refs[last];
                            slot_tag[hit]  = slot_tag[last];
                        end
                    end
                end
            end else begin
                mask   = (w.mem_type == rrc_pkg::MEM_DEVICE) ? rrc_pkg::DEVICE_MASK
                                                             : (64'd1 << cfg_page_log2) - 64'd1;
                base   = w.start_address & ~mask;
                offset = w.start_address - base;
                size   = '0;
                stop   = '0;
                bad    = (w.start_address == '0) || (w.length == '0) ||
                         (w.length > ~offset);
                if (!bad) begin
                    size = w.length + offset;
                    bad  = size > ~mask;
                end
                if (!bad) begin
                    size = (size + mask) & ~mask;
                    bad  = size > ~base;
                end
                if (!bad) begin
                    stop = base + size;
                    bad  = (cfg_size_limit != '0) && (size > cfg_size_limit);
                end
                if (bad) begin
                    r.status = rrc_pkg::ST_BAD_ARG;
                end else begin
                    for (int i = 0; i < live_slots && hit < 0; i++)
                        if (slot_kind[i] == w.mem_type && slot_lo[i] <= base &&
                            stop <= slot_hi[i]) hit = i;
                    if (hit >= 0) begin
                        if (slot_refs[hit] != rrc_pkg::REFS_MAX)
                            slot_refs[hit] = slot_refs[hit] + 32'd1;
                        r.status        = rrc_pkg::ST_REUSED;
                        r.handle_out    = slot_tag[hit];
                        r.aligned_start = slot_lo[hit];
                        r.aligned_end   = slot_hi[hit];
                        r.ref_count     = slot_refs[hit];
                    end else if (live_slots >= int'(cfg_cap) || live_slots >= DEPTH) begin
                        r.status        = rrc_pkg::ST_FULL;
                        r.aligned_start = base;
                        r.aligned_end   = stop;
                    end else begin
                        slot_lo[live_slots]   = base;
                        slot_hi[live_slots]   = stop;
                        slot_kind[live_slots] = w.mem_type;
                        slot_refs[live_slots] = 32'd1;
                        slot_tag[live_slots]  = tag_next;
                        r.status        = rrc_pkg::ST_NEW;
                        r.handle_out    = tag_next;
                        r.aligned_start = base;
                        r.aligned_end   = stop;
                        r.ref_count     = 32'd1;
                        tag_next        = tag_next + 16'd1;
                        live_slots      = live_slots + 1;
                    end
                end
            end
            pending_rsp.push_back(r);
        endfunction

        function void check_result(rrc_pkg::t_rsp got);
            rrc_pkg::t_rsp exp;

            if (pending_rsp.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result word with nothing outstanding: %h", got);
                return;
            end
            exp = pending_rsp.pop_front();
            seen[exp.status]++;
            if (got.status !== exp.status || got.handle_out !== exp.handle_out ||
                got.aligned_start !== exp.aligned_start ||
                got.aligned_end !== exp.aligned_end || got.ref_count !== exp.ref_count) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: mismatch at %0t", $realtime);
                    $display("  expected st=%0d h=%h s=%h e=%h refs=%h", exp.status,
                             exp.handle_out, exp.aligned_start, exp.aligned_end,
                             exp.ref_count);
                    $display("  actual   st=%0d h=%h s=%h e=%h refs=%h", got.status,
                             got.handle_out, got.aligned_start, got.aligned_end,
                             got.ref_count);
                end
            end
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test. Everything the testbench drives has
    // a known value from time zero.
    // ------------------------------------------------------------------------
    logic          clk;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    rrc_pkg::t_req req_word  = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    rrc_pkg::t_rsp rsp_word;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [63:0]   cfg_data  = '0;

    // Idling is switched off for the closing phase; hold_req asks the result
    // side for one long hold-off so that the block backs up into the request
    // channel.
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int stall_cycles = 0;

    region_cache_scoreboard cache_sb;

    region_registration_cache_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_word   (req_word),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_word  (rsp_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock, rising edges at 2, 6, 10 ns and so on.
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Result side. Ready changes on falling edges only; result words are
    // taken on rising edges where valid and ready are both high.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                // Long hold-off, counted here while the sender keeps going.
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) cache_sb.check_result(rsp_word);
    end

    // Watchdog: a long run of cycles without any handshake on any channel
    // means the block has hung.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles, %0d words outstanding",
                     STALL_LIMIT, cache_sb.outstanding());
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Offers one request word, optionally after an idle burst, and holds it
    // until it is taken. The prediction is made at the accepting edge.
    task automatic put_request(input rrc_pkg::t_req w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (!req_ready);
        cache_sb.note_request(w);
        @(negedge clk);
    endtask

    function automatic rrc_pkg::t_req make_req(logic kind, logic [63:0] addr,
                                               logic [63:0] len, logic mem,
                                               logic [15:0] handle);
        rrc_pkg::t_req w;
        w.req_type      = kind;
        w.start_address = addr;
        w.length        = len;
        w.mem_type      = mem;
        w.entry_handle  = handle;
        return w;
    endfunction

    // Waits until every result word has come back, then lets the block settle
    // before the settings change or the run ends.
    task automatic drain_pipeline();
        req_valid <= 1'b0;
        while (cache_sb.outstanding() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cache_sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // One setting per phase: the admission limit, the size limit and the host
    // page size, with the extremes of each among them.
    task automatic apply_setting(input int phase);
        logic [6:0]  cap;
        logic [63:0] limit;
        logic [4:0]  log2;

        case (phase)
            0:       begin cap = 7'd64;  limit = '0;           log2 = 5'd12; end
            1:       begin cap = 7'd4;   limit = '0;           log2 = 5'd21; end
            2:       begin cap = 7'd1;   limit = 64'd1 << 20;  log2 = 5'd16; end
            3:       begin cap = 7'd127; limit = '1;           log2 = 5'd0;  end
            4:       begin cap = 7'd0;   limit = '0;           log2 = 5'd31; end
            5:       begin cap = 7'd64;  limit = 64'h1_0000;   log2 = 5'd12; end
            default: begin cap = 7'd64;  limit = '0;           log2 = 5'd14; end
        endcase
        write_config(rrc_pkg::CFG_MAX_ENTRIES, 64'(cap));
        write_config(rrc_pkg::CFG_MAX_REGION_SIZE, limit);
        write_config(rrc_pkg::CFG_HOST_PAGE_LOG2, 64'(log2));
        cfg_valid <= 1'b0;
    endtask

    // Short directed sequence from the reset settings (64 slots, no size
    // limit, 4 KiB host pages). Handles count up from zero after reset.
    task automatic run_directed();
        rrc_pkg::t_req seq [$];

        // Insert, hit on a contained host range, and a device miss at the
        // same address since the memory type differs.
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h1234, 64'h10,
                               rrc_pkg::MEM_HOST, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h1800, 64'h100,
                               rrc_pkg::MEM_HOST, 16'hFFFF));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h1234, 64'h10,
                               rrc_pkg::MEM_DEVICE, 16'h0));
        // Zero address, zero length, and each of the overflow cases: end past
        // the top, length plus offset, rounding up, and base plus size.
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h0, 64'h10,
                               rrc_pkg::MEM_HOST, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h5000, 64'h0,
                               rrc_pkg::MEM_HOST, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'hFFFF_FFFF_FFFF_F001, 64'h1000,
                               rrc_pkg::MEM_HOST, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h1, '1,
                               rrc_pkg::MEM_HOST, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, '1, 64'h1,
                               rrc_pkg::MEM_DEVICE, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h1000, 64'hFFFF_FFFF_FFFF_F001,
                               rrc_pkg::MEM_HOST, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h8000_0000_0000_0000,
                               64'h7FFF_FFFF_FFFF_F001, rrc_pkg::MEM_HOST, 16'h0));
        // Largest range that still fits below the top of the address space.
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h8000_0000_0000_0000,
                               64'h7FFF_FFFF_FFFF_F000, rrc_pkg::MEM_HOST, 16'h0));
        // Release down to zero with noise in the unused fields; the highest
        // slot moves into slot zero, then the handle is gone.
        seq.push_back(make_req(rrc_pkg::REQ_RELEASE, '1, '1, rrc_pkg::MEM_DEVICE, 16'd0));
        seq.push_back(make_req(rrc_pkg::REQ_RELEASE, '0, '0, rrc_pkg::MEM_HOST, 16'd0));
        seq.push_back(make_req(rrc_pkg::REQ_RELEASE, '1, '0, rrc_pkg::MEM_HOST, 16'd0));
        seq.push_back(make_req(rrc_pkg::REQ_RELEASE, '0, '1, rrc_pkg::MEM_DEVICE, 16'hFFFF));
        // Device page widening, a hit on the moved slot and more releases.
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h1_2345, 64'h100,
                               rrc_pkg::MEM_DEVICE, 16'hFFFF));
        seq.push_back(make_req(rrc_pkg::REQ_RELEASE, '0, '0, rrc_pkg::MEM_HOST, 16'd1));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h1_0000, 64'h1_0000,
                               rrc_pkg::MEM_DEVICE, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_REGISTER, 64'h9000_0000_0000_0000, 64'h10,
                               rrc_pkg::MEM_HOST, 16'h0));
        seq.push_back(make_req(rrc_pkg::REQ_RELEASE, '0, '0, rrc_pkg::MEM_HOST, 16'd2));
        foreach (seq[k]) put_request(seq[k]);
    endtask

    // Random requests. Most are well-formed against the live table: ranges
    // inside live entries (hits), releases of live handles, and fresh ranges
    // from a compact address window; the rest are bad arguments, unknown
    // handles and fully random words. Unused fields always carry noise.
    task automatic run_random(input int count);
        rrc_pkg::t_req w;
        int            pick, j;
        logic [63:0]   span, room;

        for (int k = 0; k < count; k++) begin
            w.req_type      = 1'($urandom);
            w.start_address = {$urandom, $urandom};
            w.length        = {$urandom, $urandom};
            w.mem_type      = 1'($urandom);
            w.entry_handle  = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (cache_sb.live_slots == 0 && pick >= 30 && pick < 85) pick = 0;
            if (pick < 30) begin
                w.req_type      = rrc_pkg::REQ_REGISTER;
                w.start_address = (64'($urandom_range(1, 255)) << 16) |
                                  64'($urandom_range(0, 16'hFFFF));
                if ($urandom_range(0, 7) == 0) w.start_address[63:32] = $urandom;
                w.length = 64'($urandom_range(1, 1 << $urandom_range(4, 20)));
            end else if (pick < 55) begin
                j               = $urandom_range(0, cache_sb.live_slots - 1);
                span            = cache_sb.slot_hi[j] - cache_sb.slot_lo[j];
                w.req_type      = rrc_pkg::REQ_REGISTER;
                w.mem_type      = cache_sb.slot_kind[j];
                w.start_address = cache_sb.slot_lo[j] + ({$urandom, $urandom} % span);
                room            = cache_sb.slot_hi[j] - w.start_address;
                w.length        = 64'd1 + ({$urandom, $urandom} % room);
            end else if (pick < 85) begin
                j              = $urandom_range(0, cache_sb.live_slots - 1);
                w.req_type     = rrc_pkg::REQ_RELEASE;
                w.entry_handle = cache_sb.slot_tag[j];
            end else if (pick < 90) begin
                w.req_type = rrc_pkg::REQ_RELEASE;
            end else if (pick < 95) begin
                w.req_type = rrc_pkg::REQ_REGISTER;
                case ($urandom_range(0, 2))
                    0:       w.start_address = '0;
                    1:       w.length = '0;
                    default: w.start_address = ~64'($urandom_range(0, 16'hFFFF));
                endcase
            end else begin
                w.req_type = rrc_pkg::REQ_REGISTER;
            end
            put_request(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run: reset, directed words at the reset settings, then
    // one random phase per setting. The first programmed phase carries the
    // long result hold-off, and the last one runs without any idling.
    // ------------------------------------------------------------------------
    initial begin
        cache_sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(ITEMS_PER_PHASE);
        for (int p = 0; p <= LAST_PHASE; p++) begin
            drain_pipeline();
            apply_setting(p);
            if (p == 0) hold_req = 1'b1;
            if (p == LAST_PHASE) idle_on = 1'b0;
            run_random(ITEMS_PER_PHASE);
        end
        drain_pipeline();

        $display("Run covered %0d requests over %0d settings: new %0d, reused %0d,",
                 cache_sb.requests, LAST_PHASE + 2, cache_sb.seen[rrc_pkg::ST_NEW],
                 cache_sb.seen[rrc_pkg::ST_REUSED]);
        $display("last released %0d, still referenced %0d, bad argument %0d,",
                 cache_sb.seen[rrc_pkg::ST_LAST_REL], cache_sb.seen[rrc_pkg::ST_STILL_REF],
                 cache_sb.seen[rrc_pkg::ST_BAD_ARG]);
        $display("full %0d, not found %0d.", cache_sb.seen[rrc_pkg::ST_FULL],
                 cache_sb.seen[rrc_pkg::ST_NOT_FOUND]);
        if (cache_sb.failures == 0 && cache_sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures, %0d words still outstanding", cache_sb.failures,
                     cache_sb.outstanding());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rrc_pkg.sv
rtl/rrc_entry_ram.sv
rtl/rrc_match.sv
rtl/region_registration_cache_top.sv
tb/region_registration_cache_top_tb.sv
